// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL.
// Define NO_ASSERTIONS to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check on every rising clock edge outside of reset.
`define ASSERT_RST(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check on every rising clock edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define ASSERT_RST(lbl, clk, rst, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ----- rtl/skse_pkg.sv -----
`default_nettype none

package skse_pkg;

   // Default sizing of the key store.
   localparam int DEF_CAPACITY  = 64;
   localparam int DEF_KEY_WIDTH = 32;

   // Width of the failure counters.
   localparam int FAIL_W = 32;

   // Request actions.
   typedef enum logic [1:0] {
      ACT_MEMBER = 2'd0,
      ACT_INSERT = 2'd1,
      ACT_DELETE = 2'd2,
      ACT_CLEAR  = 2'd3
   } action_type;

   // Controller states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SEARCH_RD,
      ST_SEARCH_CMP,
      ST_CHECK_RD,
      ST_CHECK_CMP,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_PUT,
      ST_DONE
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;        // capture the key and open the search window
      logic clear;       // empty the set
      logic rd_mid;      // read the middle of the search window
      logic step;        // narrow the search window
      logic rd_pos;      // read the entry at the found position
      logic shift_init;  // set up the shift index
      logic shift_rd;    // read the neighbor of the shift index
      logic shift_wr;    // move the read entry into place
      logic ins_dir;     // shift upward for an insert, downward for a delete
      logic put;         // write the new key and grow the set
      logic shrink;      // drop one entry from the set
      logic dup;         // count a duplicate insert
      logic miss;        // count a delete of an absent key
      logic publish;     // load the result register
      logic res_hit;     // hit flag of the result
      logic res_full;    // full reject flag of the result
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic search_done;  // search window is empty
      logic found;        // entry at the position equals the key
      logic full;         // store holds its capacity
      logic idx_gt_lo;    // insert shift still has entries to move
      logic idx_last;     // delete shift has reached the last entry
   } dp_status_type;

endpackage

`default_nettype wire

// ----- rtl/skse_ifs.sv -----
`default_nettype none

// Request channel: one action and one key per transaction.
interface skse_req_if #(
   parameter int KEY_WIDTH = skse_pkg::DEF_KEY_WIDTH
);
   logic                        valid;
   logic                        ready;
   logic [1:0]                  action;
   logic signed [KEY_WIDTH-1:0] key;

   modport source (output valid, output action, output key, input ready);
   modport sink   (input valid, input action, input key, output ready);
endinterface

// Response channel: one result per request.
interface skse_rsp_if #(
   parameter int CNT_W = 7
);
   logic                      valid;
   logic                      ready;
   logic                      hit;
   logic                      full_reject;
   logic [CNT_W-1:0]          entry_count;
   logic                      set_empty;
   logic [skse_pkg::FAIL_W-1:0] failed_inserts;
   logic [skse_pkg::FAIL_W-1:0] failed_deletes;

   modport source (output valid, output hit, output full_reject, output entry_count,
                   output set_empty, output failed_inserts, output failed_deletes,
                   input ready);
   modport sink   (input valid, input hit, input full_reject, input entry_count,
                   input set_empty, input failed_inserts, input failed_deletes,
                   output ready);
endinterface

`default_nettype wire

// ----- rtl/sorted_key_set_engine.sv -----
`default_nettype none
`include "assert_macros.svh"

// Channel   Direction  Payload
// req_ch    in         action, key
// rsp_ch    out        hit, full_reject, entry_count, set_empty,
//                      failed_inserts, failed_deletes
//
// A request passes through entry and search setup, binary search steps over the held
// entries (at most ceil(log2(count + 1)) steps), a check of the found entry and publishing.
// Insert and delete also move entries through the key store, one read and one write per
// entry, before an insert writes its key; clear goes straight to publishing.
// Synchronous reset empties the set and zeroes both failure counters; the store needs no sweep.
// A finished result waits in its own register, so a new request is taken while it stalls.

module sorted_key_set_engine #(
   parameter int CAPACITY  = skse_pkg::DEF_CAPACITY,
   parameter int KEY_WIDTH = skse_pkg::DEF_KEY_WIDTH
) (
   input  logic       clock,
   input  logic       reset,
   skse_req_if.sink   req_ch,
   skse_rsp_if.source rsp_ch
);
   import skse_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam logic [CNT_W-1:0] CAP_COUNT = CNT_W'(CAPACITY);

   dp_cmd_type    cmd;
   dp_status_type status;
   logic          count_ok;
   logic          reject_ok;
   logic          store_ok;

   // Sequencing of each transaction.
   skse_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_ch.valid),
      .req_action (action_type'(req_ch.action)),
      .req_ready  (req_ch.ready),
      .rsp_valid  (rsp_ch.valid),
      .rsp_ready  (rsp_ch.ready),
      .cmd        (cmd),
      .status     (status)
   );

   // Key store, search window, counters and result register.
   skse_datapath #(
      .CAPACITY  (CAPACITY),
      .KEY_WIDTH (KEY_WIDTH),
      .CNT_W     (CNT_W)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .req_key            (req_ch.key),
      .cmd                (cmd),
      .status             (status),
      .rsp_hit            (rsp_ch.hit),
      .rsp_full_reject    (rsp_ch.full_reject),
      .rsp_entry_count    (rsp_ch.entry_count),
      .rsp_set_empty      (rsp_ch.set_empty),
      .rsp_failed_inserts (rsp_ch.failed_inserts),
      .rsp_failed_deletes (rsp_ch.failed_deletes)
   );

   // Conditions watched by the checks below.
   assign count_ok  = !rsp_ch.valid || (rsp_ch.entry_count <= CAP_COUNT);
   assign reject_ok = !(rsp_ch.valid && rsp_ch.hit && rsp_ch.full_reject);
   assign store_ok  = !((cmd.shift_wr || cmd.put) && (cmd.rd_mid || cmd.rd_pos || cmd.shift_rd));

   // The reported count never exceeds the capacity.
   `ASSERT_RST(a_count_bound, clock, reset, count_ok, "entry count above capacity")

   // A refused insert never reports a hit.
   `ASSERT_RST(a_reject_no_hit, clock, reset, reject_ok, "hit and full reject together")

   // Publishing a result returns the controller to taking requests.
   `ASSERT_RST(a_publish_ready, clock, reset, cmd.publish |=> req_ch.ready, "ready low after publish")

   // The store is never written and read in the same cycle.
   `ASSERT_ALWAYS(a_port_excl, clock, store_ok, "store read and written together")

endmodule

`default_nettype wire

// ----- rtl/skse_datapath.sv -----
`default_nettype none

module skse_datapath #(
   parameter int CAPACITY  = skse_pkg::DEF_CAPACITY,
   parameter int KEY_WIDTH = skse_pkg::DEF_KEY_WIDTH,
   parameter int CNT_W     = $clog2(CAPACITY + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic signed [KEY_WIDTH-1:0]   req_key,
   input  skse_pkg::dp_cmd_type          cmd,
   output skse_pkg::dp_status_type       status,
   output logic                          rsp_hit,
   output logic                          rsp_full_reject,
   output logic [CNT_W-1:0]              rsp_entry_count,
   output logic                          rsp_set_empty,
   output logic [skse_pkg::FAIL_W-1:0]   rsp_failed_inserts,
   output logic [skse_pkg::FAIL_W-1:0]   rsp_failed_deletes
);
   import skse_pkg::*;

   localparam int IDX_W = $clog2(CAPACITY);

   // Key store, kept with the sign bit flipped so that unsigned order is signed order.
   logic [KEY_WIDTH-1:0] key_mem [CAPACITY];
   logic [KEY_WIDTH-1:0] rd_data_ff;

   logic [KEY_WIDTH-1:0] key_ff, key_in;
   logic [CNT_W-1:0]     lo_ff, lo_in;
   logic [CNT_W-1:0]     hi_ff, hi_in;
   logic [CNT_W-1:0]     idx_ff, idx_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [FAIL_W-1:0]    dup_ff, dup_in;
   logic [FAIL_W-1:0]    miss_ff, miss_in;

   logic [CNT_W:0]       mid_sum;
   logic [CNT_W-1:0]     mid;
   logic [CNT_W-1:0]     rd_addr;
   logic [CNT_W-1:0]     wr_addr;
   logic [KEY_WIDTH-1:0] wr_data;
   logic                 rd_en;
   logic                 wr_en;

   // Middle of the search window.
   assign mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid     = mid_sum[CNT_W:1];

   // Memory port selection.
   always_comb begin
      rd_en = cmd.rd_mid | cmd.rd_pos | cmd.shift_rd;
      if (cmd.rd_mid) begin
         rd_addr = mid;
      end else if (cmd.rd_pos) begin
         rd_addr = lo_ff;
      end else if (cmd.ins_dir) begin
         rd_addr = idx_ff - CNT_W'(1);
      end else begin
         rd_addr = idx_ff + CNT_W'(1);
      end
      wr_en = cmd.shift_wr | cmd.put;
      if (cmd.put) begin
         wr_addr = lo_ff;
         wr_data = key_ff;
      end else begin
         wr_addr = idx_ff;
         wr_data = rd_data_ff;
      end
   end

   // Key store with a registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[wr_addr[IDX_W-1:0]] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= key_mem[rd_addr[IDX_W-1:0]];
      end
   end

   // Working registers: key, search window, shift index, count and counters.
   always_comb begin
      key_in   = key_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      idx_in   = idx_ff;
      count_in = count_ff;
      dup_in   = dup_ff;
      miss_in  = miss_ff;
      if (cmd.load) begin
         key_in = {~req_key[KEY_WIDTH-1], req_key[KEY_WIDTH-2:0]};
         lo_in  = '0;
         hi_in  = count_ff;
      end
      if (cmd.step) begin
         if (rd_data_ff < key_ff) begin
            lo_in = mid + CNT_W'(1);
         end else begin
            hi_in = mid;
         end
      end
      if (cmd.shift_init) begin
         idx_in = cmd.ins_dir ? count_ff : lo_ff;
      end else if (cmd.shift_wr) begin
         idx_in = cmd.ins_dir ? idx_ff - CNT_W'(1) : idx_ff + CNT_W'(1);
      end
      if (cmd.clear) begin
         count_in = '0;
      end else if (cmd.put) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.shrink) begin
         count_in = count_ff - CNT_W'(1);
      end
      if (cmd.dup) begin
         dup_in = dup_ff + FAIL_W'(1);
      end
      if (cmd.miss) begin
         miss_in = miss_ff + FAIL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         dup_ff   <= '0;
         miss_ff  <= '0;
      end else begin
         count_ff <= count_in;
         dup_ff   <= dup_in;
         miss_ff  <= miss_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      lo_ff  <= lo_in;
      hi_ff  <= hi_in;
      idx_ff <= idx_in;
   end

   // Status toward the controller.
   always_comb begin
      status.search_done = (lo_ff == hi_ff);
      status.found       = (lo_ff < count_ff) && (rd_data_ff == key_ff);
      status.full        = (count_ff == CNT_W'(CAPACITY));
      status.idx_gt_lo   = (idx_ff > lo_ff);
      status.idx_last    = ((idx_ff + CNT_W'(1)) >= count_ff);
   end

   // Result register, loaded once the request is finished.
   always_ff @(posedge clock) begin
      if (cmd.publish) begin
         rsp_hit            <= cmd.res_hit;
         rsp_full_reject    <= cmd.res_full;
         rsp_entry_count    <= count_ff;
         rsp_set_empty      <= (count_ff == '0);
         rsp_failed_inserts <= dup_ff;
         rsp_failed_deletes <= miss_ff;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/skse_controller.sv -----
`default_nettype none

module skse_controller (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  skse_pkg::action_type    req_action,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output skse_pkg::dp_cmd_type    cmd,
   input  skse_pkg::dp_status_type status
);
   import skse_pkg::*;

   state_type  state_ff, state_in;
   action_type act_ff, act_in;
   logic       hit_ff, hit_in;
   logic       full_ff, full_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   // The result register is free when empty or being taken this cycle.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff  <= act_in;
      hit_ff  <= hit_in;
      full_ff <= full_in;
   end

   // Next state and datapath commands.
   always_comb begin
      state_in     = state_ff;
      act_in       = act_ff;
      hit_in       = hit_ff;
      full_in      = full_ff;
      cmd          = '0;
      cmd.ins_dir  = (act_ff == ACT_INSERT);
      cmd.res_hit  = hit_ff;
      cmd.res_full = full_ff;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               act_in  = req_action;
               hit_in  = 1'b0;
               full_in = 1'b0;
               if (req_action == ACT_CLEAR) begin
                  cmd.clear = 1'b1;
                  hit_in    = 1'b1;
                  state_in  = ST_DONE;
               end else begin
                  cmd.load = 1'b1;
                  state_in = ST_SEARCH_RD;
               end
            end
         end
         ST_SEARCH_RD: begin
            if (status.search_done) begin
               state_in = ST_CHECK_RD;
            end else begin
               cmd.rd_mid = 1'b1;
               state_in   = ST_SEARCH_CMP;
            end
         end
         ST_SEARCH_CMP: begin
            cmd.step = 1'b1;
            state_in = ST_SEARCH_RD;
         end
         ST_CHECK_RD: begin
            cmd.rd_pos = 1'b1;
            state_in   = ST_CHECK_CMP;
         end
         ST_CHECK_CMP: begin
            state_in = ST_DONE;
            unique case (act_ff)
               ACT_MEMBER: begin
                  hit_in = status.found;
               end
               ACT_INSERT: begin
                  if (status.found) begin
                     cmd.dup = 1'b1;
                  end else if (status.full) begin
                     full_in = 1'b1;
                  end else begin
                     cmd.shift_init = 1'b1;
                     state_in       = ST_SHIFT_RD;
                  end
               end
               ACT_DELETE: begin
                  if (status.found) begin
                     cmd.shift_init = 1'b1;
                     state_in       = ST_SHIFT_RD;
                  end else begin
                     cmd.miss = 1'b1;
                  end
               end
               ACT_CLEAR: begin
                  hit_in = 1'b1;
               end
               default: begin
                  hit_in = 1'b0;
               end
            endcase
         end
         ST_SHIFT_RD: begin
            if (act_ff == ACT_INSERT) begin
               if (status.idx_gt_lo) begin
                  cmd.shift_rd = 1'b1;
                  state_in     = ST_SHIFT_WR;
               end else begin
                  state_in = ST_PUT;
               end
            end else begin
               if (!status.idx_last) begin
                  cmd.shift_rd = 1'b1;
                  state_in     = ST_SHIFT_WR;
               end else begin
                  cmd.shrink = 1'b1;
                  hit_in     = 1'b1;
                  state_in   = ST_DONE;
               end
            end
         end
         ST_SHIFT_WR: begin
            cmd.shift_wr = 1'b1;
            state_in     = ST_SHIFT_RD;
         end
         ST_PUT: begin
            cmd.put  = 1'b1;
            hit_in   = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.publish  = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ----- verif/sorted_key_set_engine_test.sv -----
`timescale 1ns / 100ps

module sorted_key_set_engine_test;

   import skse_pkg::*;

   localparam int CAPACITY        = DEF_CAPACITY;
   localparam int KEY_W           = DEF_KEY_WIDTH;
   localparam int COUNT_W         = $clog2(CAPACITY + 1);
   localparam int MAX_GAP         = 13;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int WATCHDOG_LIMIT  = 4000;
   localparam int DRAIN_CYCLES    = 300;
   localparam int MAX_REPORTED    = 10;

   typedef logic signed [KEY_W-1:0] key_type;

   localparam key_type KEY_MIN = {1'b1, {(KEY_W - 1){1'b0}}};
   localparam key_type KEY_MAX = {1'b0, {(KEY_W - 1){1'b1}}};

   typedef struct packed {
      logic               hit;
      logic               full_reject;
      logic [COUNT_W-1:0] entry_count;
      logic               set_empty;
      logic [FAIL_W-1:0]  failed_inserts;
      logic [FAIL_W-1:0]  failed_deletes;
   } set_result_type;

   logic clock;
   logic reset;

   skse_req_if #(.KEY_WIDTH(KEY_W)) req_ch ();
   skse_rsp_if #(.CNT_W(COUNT_W))   rsp_ch ();

   sorted_key_set_engine #(
      .CAPACITY (CAPACITY),
      .KEY_WIDTH(KEY_W)
   ) i_dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   // Shadow copy of the set and its failure counters, kept in ascending order.
   key_type           sorted_keys[$];
   logic [FAIL_W-1:0] dup_inserts;
   logic [FAIL_W-1:0] miss_deletes;

   set_result_type pending_set_results[$];
   int             failures;
   int             results_seen;
   int             idle_cycles;
   bit             no_idle;
   bit             hold_off_pending;

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Applies one request to the shadow set and returns the result it must produce.
   function automatic set_result_type apply_set_request(action_type act, key_type k);
      set_result_type r;
      int             pos;
      bit             found;
      pos = 0;
      while (pos < sorted_keys.size() && sorted_keys[pos] < k) pos++;
      found = (pos < sorted_keys.size()) && (sorted_keys[pos] == k);
      r = '0;
      case (act)
         ACT_MEMBER: begin
            r.hit = found;
         end
         ACT_INSERT: begin
            if (found) begin
               dup_inserts++;
            end else if (sorted_keys.size() >= CAPACITY) begin
               r.full_reject = 1'b1;
            end else begin
               sorted_keys.insert(pos, k);
               r.hit = 1'b1;
            end
         end
         ACT_DELETE: begin
            if (found) begin
               sorted_keys.delete(pos);
               r.hit = 1'b1;
            end else begin
               miss_deletes++;
            end
         end
         default: begin
            sorted_keys.delete();
            r.hit = 1'b1;
         end
      endcase
      r.entry_count    = COUNT_W'(sorted_keys.size());
      r.set_empty      = (sorted_keys.size() == 0);
      r.failed_inserts = dup_inserts;
      r.failed_deletes = miss_deletes;
      return r;
   endfunction

   function automatic void note_failure(string msg);
      failures++;
      if (failures <= MAX_REPORTED) $display("%t: %s", $realtime, msg);
   endfunction

   // Keys cluster on a small range and the extremes so that hits are common.
   function automatic key_type draw_key();
      key_type k;
      case ($urandom_range(0, 9))
         0, 1, 2: k = key_type'($urandom);
         3: begin
            case ($urandom_range(0, 3))
               0:       k = KEY_MIN;
               1:       k = KEY_MAX;
               2:       k = -1;
               default: k = 0;
            endcase
         end
         default: k = key_type'(int'($urandom_range(0, 39)) - 20);
      endcase
      return k;
   endfunction

   function automatic key_type draw_held_key();
      key_type k;
      if (sorted_keys.size() == 0) k = draw_key();
      else k = sorted_keys[$urandom_range(0, sorted_keys.size() - 1)];
      return k;
   endfunction

   // Offers one request and records its expected result once the transaction completes.
   task automatic send_request(action_type act, key_type k);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid  <= 1'b1;
      req_ch.action <= act;
      req_ch.key    <= k;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      pending_set_results.push_back(apply_set_request(act, k));
   endtask

   // Compares one accepted result with the oldest expectation, field by field.
   task automatic check_set_result(set_result_type got);
      set_result_type want;
      string          diffs;
      results_seen++;
      if (pending_set_results.size() == 0) begin
         note_failure($sformatf("result %0d arrived with none expected: %p", results_seen, got));
         return;
      end
      want  = pending_set_results.pop_front();
      diffs = "";
      if (got.hit !== want.hit)
         diffs = {diffs, $sformatf(" hit exp %0b got %0b", want.hit, got.hit)};
      if (got.full_reject !== want.full_reject)
         diffs = {diffs, $sformatf(" full_reject exp %0b got %0b",
                                   want.full_reject, got.full_reject)};
      if (got.entry_count !== want.entry_count)
         diffs = {diffs, $sformatf(" entry_count exp %0d got %0d",
                                   want.entry_count, got.entry_count)};
      if (got.set_empty !== want.set_empty)
         diffs = {diffs, $sformatf(" set_empty exp %0b got %0b", want.set_empty, got.set_empty)};
      if (got.failed_inserts !== want.failed_inserts)
         diffs = {diffs, $sformatf(" failed_inserts exp %0d got %0d",
                                   want.failed_inserts, got.failed_inserts)};
      if (got.failed_deletes !== want.failed_deletes)
         diffs = {diffs, $sformatf(" failed_deletes exp %0d got %0d",
                                   want.failed_deletes, got.failed_deletes)};
      if (diffs != "") note_failure($sformatf("result %0d mismatch:%s", results_seen, diffs));
   endtask

   // Result side: random stalls, an occasional long hold-off, and a check of every transaction.
   initial begin : result_side
      int             stall;
      set_result_type got;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, MAX_GAP);
         if (hold_off_pending) begin
            stall            = HOLD_OFF_CYCLES;
            hold_off_pending = 1'b0;
         end
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_ch.valid) @(posedge clock);
         got.hit            = rsp_ch.hit;
         got.full_reject    = rsp_ch.full_reject;
         got.entry_count    = rsp_ch.entry_count;
         got.set_empty      = rsp_ch.set_empty;
         got.failed_inserts = rsp_ch.failed_inserts;
         got.failed_deletes = rsp_ch.failed_deletes;
         check_set_result(got);
      end
   end

   // Watchdog: ends the run when no transaction completes on either channel for too long.
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("** sorted_key_set_engine: FAILED **");
         $finish;
      end
   end

   // Extremes of the key, every action, duplicates, misses and clearing.
   task automatic test_directed_cases();
      send_request(ACT_MEMBER, KEY_MIN);
      send_request(ACT_DELETE, 0);
      send_request(ACT_INSERT, 0);
      send_request(ACT_INSERT, KEY_MIN);
      send_request(ACT_INSERT, KEY_MAX);
      send_request(ACT_INSERT, -1);
      send_request(ACT_INSERT, 1);
      send_request(ACT_INSERT, 0);
      send_request(ACT_MEMBER, KEY_MIN);
      send_request(ACT_MEMBER, KEY_MAX);
      send_request(ACT_MEMBER, 2);
      send_request(ACT_DELETE, -1);
      send_request(ACT_DELETE, -1);
      send_request(ACT_INSERT, key_type'(32'h5555_5555));
      send_request(ACT_INSERT, key_type'(32'hAAAA_AAAA));
      send_request(ACT_DELETE, KEY_MAX);
      send_request(ACT_CLEAR, key_type'(32'hFFFF_FFFF));
      send_request(ACT_MEMBER, 0);
      send_request(ACT_CLEAR, 0);
      send_request(ACT_INSERT, KEY_MAX);
   endtask

   // Fills the set to capacity, works on the full set, then drains part or all of it.
   task automatic test_full_set();
      int target;
      for (int round = 0; round < 4; round++) begin
         no_idle = (round == 2);
         while (sorted_keys.size() < CAPACITY) begin
            if ($urandom_range(0, 4) == 0) send_request(ACT_MEMBER, draw_held_key());
            else if ($urandom_range(0, 1) == 0) send_request(ACT_INSERT, draw_key());
            else send_request(ACT_INSERT, key_type'($urandom));
         end
         // A new key is refused here, while a held key still counts as a duplicate.
         repeat (12) begin
            case ($urandom_range(0, 3))
               0, 1:    send_request(ACT_INSERT, key_type'($urandom));
               2:       send_request(ACT_INSERT, draw_held_key());
               default: send_request(ACT_MEMBER, draw_held_key());
            endcase
         end
         target = $urandom_range(0, CAPACITY / 2);
         while (sorted_keys.size() > target) begin
            if ($urandom_range(0, 5) == 0) send_request(ACT_DELETE, draw_key());
            else send_request(ACT_DELETE, draw_held_key());
         end
         if (round % 2 == 1) send_request(ACT_CLEAR, draw_key());
      end
      no_idle = 1'b0;
   endtask

   // Random mix of actions over a narrow key range, with bursts that never idle.
   task automatic test_random_mix();
      int pick;
      for (int n = 0; n < 600; n++) begin
         if (n % 100 == 60) no_idle = 1'b1;
         else if (n % 100 == 0) no_idle = 1'b0;
         pick = $urandom_range(0, 99);
         if (pick < 2) begin
            send_request(ACT_CLEAR, draw_key());
         end else if (pick < 32) begin
            send_request(ACT_MEMBER, $urandom_range(0, 1) ? draw_held_key() : draw_key());
         end else if (pick < 67) begin
            send_request(ACT_INSERT, draw_key());
         end else begin
            send_request(ACT_DELETE, $urandom_range(0, 1) ? draw_held_key() : draw_key());
         end
      end
      no_idle = 1'b0;
   endtask

   // The result side holds off for a long stretch while requests keep coming.
   task automatic test_result_backpressure();
      no_idle          = 1'b1;
      hold_off_pending = 1'b1;
      repeat (40) begin
         if ($urandom_range(0, 1) == 0) send_request(ACT_INSERT, draw_key());
         else send_request(ACT_MEMBER, draw_held_key());
      end
      no_idle = 1'b0;
   endtask

   // Reset, the test sequence and the final verdict.
   initial begin : stimulus
      req_ch.valid     = 1'b0;
      req_ch.action    = ACT_MEMBER;
      req_ch.key       = '0;
      rsp_ch.ready     = 1'b0;
      reset            = 1'b1;
      dup_inserts      = '0;
      miss_deletes     = '0;
      failures         = 0;
      results_seen     = 0;
      idle_cycles      = 0;
      no_idle          = 1'b0;
      hold_off_pending = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_directed_cases();
      test_full_set();
      test_random_mix();
      test_result_backpressure();

      req_ch.valid <= 1'b0;
      while (pending_set_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (failures == 0 && pending_set_results.size() == 0) begin
         $display("** sorted_key_set_engine: PASSED **");
      end else begin
         $display("** sorted_key_set_engine: FAILED **");
      end
      $finish;
   end

endmodule
